// ===== rtl/core/tlbfl_pkg.sv =====
// Shared constants and types for the TLB lookup unit.
// No dependencies; imported by the cells, the divider and the top level.
`default_nettype none

package tlbfl_pkg;

   localparam int ENTRIES     = 16;
   localparam int ADDR_W      = 31;
   localparam int PSIZE_W     = 16;
   localparam int CAP_W       = 5;
   localparam int STAT_W      = 32;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W       = $clog2(ENTRIES + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_STEPS   = ADDR_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = 16'd4096;
   localparam logic [CAP_W-1:0]   CAPACITY_RESET  = 5'd16;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SIZE = 2'd0,
      CSR_CAPACITY  = 2'd1,
      CSR_POLICY    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             search;
      logic             update;
      logic             evict;
      logic             lru_hit;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [OCC_W-1:0] occ;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/tlbfl_req_if.sv =====
// Request channel: one address per transaction.
// Depends on tlbfl_pkg.
`default_nettype none

interface tlbfl_req_if import tlbfl_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlbfl_rsp_if.sv =====
// Response channel: lookup result and running statistics per transaction.
// Depends on tlbfl_pkg.
`default_nettype none

interface tlbfl_rsp_if import tlbfl_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] page_number;
   logic              hit;
   logic              victim_valid;
   logic [ADDR_W-1:0] victim_page;
   logic [STAT_W-1:0] hit_count;
   logic [STAT_W-1:0] miss_count;

   modport source (output valid, output page_number, output hit, output victim_valid,
                   output victim_page, output hit_count, output miss_count, input ready);
   modport sink   (input valid, input page_number, input hit, input victim_valid,
                   input victim_page, input hit_count, input miss_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlbfl_div.sv =====
// Restoring divider, one quotient bit per cycle: address / page size.
// Depends on tlbfl_pkg.
`default_nettype none

module tlbfl_div import tlbfl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ADDR_W-1:0]  dividend,
   input  logic [PSIZE_W-1:0] divisor,
   output logic               done,
   output logic [ADDR_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PSIZE_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [PSIZE_W-1:0]   dvs_ff, dvs_in;
   logic [PSIZE_W:0]     rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff, quo_ff[ADDR_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? PSIZE_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[PSIZE_W-1:0];
         quo_in = {quo_ff[ADDR_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef ASSERT_OFF
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> dvs_ff != '0)
      else $error("divider running with zero divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tlbfl_cell.sv =====
// One TLB entry: holds a page, compares it, and shifts from its newer neighbor.
// Depends on tlbfl_pkg.
`default_nettype none

module tlbfl_cell import tlbfl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  cell_idx,
   input  cell_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0] key,
   input  logic [ADDR_W-1:0] nbr_page,
   input  logic              seen_in,
   output logic              seen_out,
   output logic              match,
   output logic [ADDR_W-1:0] page
);

   logic [ADDR_W-1:0] page_ff, page_in;
   logic              match_ff, match_in;
   logic              in_use;
   logic              has_next;
   logic              shift;
   logic              write;

   assign in_use   = OCC_W'(cell_idx) < ctrl.occ;
   assign has_next = ((OCC_W + 1)'(cell_idx) + (OCC_W + 1)'(1)) < (OCC_W + 1)'(ctrl.occ);
   assign seen_out = seen_in | match_ff;
   assign shift    = ctrl.update && has_next &&
                     (ctrl.evict || (ctrl.lru_hit && seen_out));
   assign write    = ctrl.update && ctrl.wr_en && (cell_idx == ctrl.wr_idx);

   always_comb begin
      if (write) begin
         page_in = key;
      end else if (shift) begin
         page_in = nbr_page;
      end else begin
         page_in = page_ff;
      end
      if (ctrl.search) begin
         match_in = in_use && (page_ff == key);
      end else if (ctrl.update) begin
         match_in = 1'b0;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
      page_ff <= page_in;
   end

   assign match = match_ff;
   assign page  = page_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tlb_fifo_lru_lookup_unit.sv =====
// Fully associative TLB lookup unit with FIFO or LRU replacement.
// Depends on tlbfl_pkg, tlbfl_req_if, tlbfl_rsp_if, tlbfl_div, tlbfl_cell.
//
// Usage:
//   req_bus carries one address per transaction (valid/ready). rsp_bus returns
//   one result per request: page number, hit, victim, and wrapping hit and
//   miss counts. csr_we/csr_index/csr_wdata write page size, capacity and
//   policy; write them only while no transaction is in flight.
// Operation:
//   Each request passes in order through the bit-serial divider, the capture
//   of the page number, the compare in all cells and the list update, which
//   registers the result. No new request is accepted until the previous one
//   has left the list update.
// Reset:
//   Synchronous, active high. Empties the TLB, clears both counters and loads
//   page size 4096, capacity 16, FIFO policy.
// Backpressure:
//   A finished result waits in the output register; the next request is still
//   accepted and divided, and its list update holds until rsp_bus is free.
`default_nettype none

module tlb_fifo_lru_lookup_unit import tlbfl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tlbfl_req_if.sink             req_bus,
   tlbfl_rsp_if.source           rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   state_type          state_ff;
   logic [PSIZE_W-1:0] page_size_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic               policy_ff;
   logic [ADDR_W-1:0]  page_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic [STAT_W-1:0]  hit_cnt_ff;
   logic [STAT_W-1:0]  miss_cnt_ff;
   logic [STAT_W-1:0]  hit_cnt_in;
   logic [STAT_W-1:0]  miss_cnt_in;

   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_page_ff;
   logic               rsp_hit_ff;
   logic               rsp_vic_valid_ff;
   logic [ADDR_W-1:0]  rsp_vic_page_ff;
   logic [STAT_W-1:0]  rsp_hit_cnt_ff;
   logic [STAT_W-1:0]  rsp_miss_cnt_ff;

   logic               req_accept;
   logic               out_free;
   logic               div_done;
   logic [ADDR_W-1:0]  div_quo;
   logic [PSIZE_W-1:0] divisor;
   logic [OCC_W-1:0]   cap_eff;
   logic               hit;
   logic               evict;
   logic               lru_hit;
   logic               room;
   cell_ctrl_type      ctrl;

   logic [ADDR_W-1:0]  cell_page [ENTRIES];
   logic [ENTRIES:0]   seen;
   logic [ENTRIES-1:0] match_vec;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign divisor       = (page_size_ff == '0) ? PSIZE_W'(1) : page_size_ff;

   tlbfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend (req_bus.address),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (int'(cap_ff) > ENTRIES) begin
         cap_eff = OCC_W'(ENTRIES);
      end else begin
         cap_eff = OCC_W'(cap_ff);
      end
   end

   assign hit     = seen[ENTRIES];
   assign room    = occ_ff < OCC_W'(ENTRIES);
   assign evict   = !hit && (occ_ff >= cap_eff) && (occ_ff != '0);
   assign lru_hit = hit && (policy_ff == POLICY_LRU);

   always_comb begin
      ctrl.search  = (state_ff == ST_SEARCH);
      ctrl.update  = (state_ff == ST_UPDATE) && out_free;
      ctrl.evict   = evict;
      ctrl.lru_hit = lru_hit;
      ctrl.wr_en   = lru_hit || evict || (!hit && room);
      ctrl.wr_idx  = (lru_hit || evict) ? IDX_W'(occ_ff - OCC_W'(1)) : IDX_W'(occ_ff);
      ctrl.occ     = occ_ff;
   end

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [ADDR_W-1:0] nbr;
      if (i == ENTRIES - 1) begin : g_last
         assign nbr = page_ff;
      end else begin : g_mid
         assign nbr = cell_page[i+1];
      end
      tlbfl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .ctrl     (ctrl),
         .key      (page_ff),
         .nbr_page (nbr),
         .seen_in  (seen[i]),
         .seen_out (seen[i+1]),
         .match    (match_vec[i]),
         .page     (cell_page[i])
      );
   end

   assign hit_cnt_in  = hit_cnt_ff + STAT_W'(hit);
   assign miss_cnt_in = miss_cnt_ff + STAT_W'(!hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_size_ff <= PAGE_SIZE_RESET;
         cap_ff       <= CAPACITY_RESET;
         policy_ff    <= POLICY_FIFO;
         occ_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PAGE_SIZE: page_size_ff <= csr_wdata[PSIZE_W-1:0];
               CSR_CAPACITY:  cap_ff       <= csr_wdata[CAP_W-1:0];
               CSR_POLICY:    policy_ff    <= csr_wdata[0];
               default:       ;
            endcase
         end
         if (ctrl.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  hit_cnt_ff   <= hit_cnt_in;
                  miss_cnt_ff  <= miss_cnt_in;
                  if (!hit && !evict && room) begin
                     occ_ff <= occ_ff + OCC_W'(1);
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         page_ff <= div_quo;
      end
      if (ctrl.update) begin
         rsp_page_ff      <= page_ff;
         rsp_hit_ff       <= hit;
         rsp_vic_valid_ff <= evict;
         rsp_vic_page_ff  <= evict ? cell_page[0] : '0;
         rsp_hit_cnt_ff   <= hit_cnt_in;
         rsp_miss_cnt_ff  <= miss_cnt_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.page_number  = rsp_page_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.victim_valid = rsp_vic_valid_ff;
   assign rsp_bus.victim_page  = rsp_vic_page_ff;
   assign rsp_bus.hit_count    = rsp_hit_cnt_ff;
   assign rsp_bus.miss_count   = rsp_miss_cnt_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("occupancy above entry count");
   a_unique_pages: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page resident in more than one entry");
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_vic_valid_ff))
      else $error("hit reported with a victim");
   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_tlb_fifo_lru_lookup_unit.sv =====
// Self-checking testbench for tlb_fifo_lru_lookup_unit: directed and random address traffic.
// A shadow TLB class predicts each response; depends on tlbfl_pkg, tlbfl_req_if, tlbfl_rsp_if.
`default_nettype none

typedef struct packed {
   logic [tlbfl_pkg::ADDR_W-1:0] page_number;
   logic                         hit;
   logic                         victim_valid;
   logic [tlbfl_pkg::ADDR_W-1:0] victim_page;
   logic [tlbfl_pkg::STAT_W-1:0] hit_count;
   logic [tlbfl_pkg::STAT_W-1:0] miss_count;
} lookup_result_type;

class tlb_shadow_type;
   bit [tlbfl_pkg::ADDR_W-1:0]  resident[tlbfl_pkg::ENTRIES];
   int unsigned                 occ;
   bit [tlbfl_pkg::STAT_W-1:0]  hits;
   bit [tlbfl_pkg::STAT_W-1:0]  misses;
   bit [tlbfl_pkg::PSIZE_W-1:0] page_size;
   bit [tlbfl_pkg::CAP_W-1:0]   capacity;
   logic                        policy;
   lookup_result_type           pending_results[$];
   int                          errors;

   function new();
      occ       = 0;
      hits      = '0;
      misses    = '0;
      page_size = tlbfl_pkg::PAGE_SIZE_RESET;
      capacity  = tlbfl_pkg::CAPACITY_RESET;
      policy    = tlbfl_pkg::POLICY_FIFO;
      errors    = 0;
      foreach (resident[i]) resident[i] = '0;
   endfunction

   function void set_reg(logic [tlbfl_pkg::CSR_IDX_W-1:0] idx,
                         logic [tlbfl_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tlbfl_pkg::CSR_PAGE_SIZE: page_size = data[tlbfl_pkg::PSIZE_W-1:0];
         tlbfl_pkg::CSR_CAPACITY:  capacity  = data[tlbfl_pkg::CAP_W-1:0];
         tlbfl_pkg::CSR_POLICY:    policy    = data[0];
         default: ;
      endcase
   endfunction

   function int unsigned outstanding();
      return pending_results.size();
   endfunction

   function void note_access(logic [tlbfl_pkg::ADDR_W-1:0] addr);
      lookup_result_type          r;
      bit [tlbfl_pkg::ADDR_W-1:0] divisor;
      bit [tlbfl_pkg::ADDR_W-1:0] page;
      int unsigned                lim;
      int unsigned                pos;
      bit                         found;
      divisor = '0;
      divisor[tlbfl_pkg::PSIZE_W-1:0] = (page_size == '0) ? 16'd1 : page_size;
      page    = addr / divisor;
      lim     = (capacity == 0) ? 1 :
                (capacity > tlbfl_pkg::ENTRIES) ? tlbfl_pkg::ENTRIES : capacity;
      found   = 1'b0;
      pos     = 0;
      r       = '0;
      for (int i = 0; i < occ; i++) begin
         if (!found && resident[i] == page) begin
            found = 1'b1;
            pos   = i;
         end
      end
      if (found) begin
         hits++;
         if (policy == tlbfl_pkg::POLICY_LRU) begin
            for (int i = pos; i + 1 < occ; i++) resident[i] = resident[i+1];
            resident[occ-1] = page;
         end
      end else begin
         misses++;
         if (occ >= lim && occ > 0) begin
            r.victim_valid = 1'b1;
            r.victim_page  = resident[0];
            for (int i = 0; i + 1 < occ; i++) resident[i] = resident[i+1];
            occ--;
         end
         if (occ < tlbfl_pkg::ENTRIES) begin
            resident[occ] = page;
            occ++;
         end
      end
      r.page_number = page;
      r.hit         = found;
      r.hit_count   = hits;
      r.miss_count  = misses;
      pending_results = {pending_results, r};
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      if (errors < 60)
         $display("mismatch %s: got %0h expected %0h", what, got, exp);
      errors++;
   endtask

   task check_result(lookup_result_type got);
      lookup_result_type exp;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected response, page", got.page_number, 0);
      end else begin
         exp = pending_results[0];
         pending_results.delete(0);
         if (got.page_number !== exp.page_number)
            report_mismatch("page_number", got.page_number, exp.page_number);
         if (got.hit !== exp.hit)
            report_mismatch("hit", got.hit, exp.hit);
         if (got.victim_valid !== exp.victim_valid)
            report_mismatch("victim_valid", got.victim_valid, exp.victim_valid);
         if (got.victim_page !== exp.victim_page)
            report_mismatch("victim_page", got.victim_page, exp.victim_page);
         if (got.hit_count !== exp.hit_count)
            report_mismatch("hit_count", got.hit_count, exp.hit_count);
         if (got.miss_count !== exp.miss_count)
            report_mismatch("miss_count", got.miss_count, exp.miss_count);
      end
   endtask
endclass

module tb_tlb_fifo_lru_lookup_unit import tlbfl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam logic [ADDR_W-1:0]    ADDR_MAX    = 31'h7FFF_FFFF;
   localparam int                   NUM_PHASES  = 20;
   localparam int                   PHASE_ITEMS = 85;
   localparam int                   DRAIN_WAIT  = 40;
   localparam int                   CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    quiet;
   int                    cycles = 0;
   tlb_shadow_type        shadow;

   tlbfl_req_if req_bus ();
   tlbfl_rsp_if rsp_bus ();

   tlb_fifo_lru_lookup_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_tlb_fifo_lru_lookup_unit: done, errors");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_access(input logic [ADDR_W-1:0] addr);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      shadow.note_access(addr);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (shadow.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      shadow.set_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] addr_in_page(longint unsigned page,
                                                      longint unsigned divisor);
      longint unsigned a;
      a = page * divisor + $urandom_range(0, divisor - 1);
      if (a > ADDR_MAX) a = ADDR_MAX;
      return a[ADDR_W-1:0];
   endfunction

   task automatic directed_checks();
      // reset defaults: 4096-byte pages, 16 entries, FIFO
      send_access('0);
      send_access(ADDR_MAX);
      send_access(31'd4095);
      send_access(31'd4096);
      send_access('0);
      drain();
      write_reg(CSR_CAPACITY, 16'hFFE2);     // capacity 2 with 3 resident
      send_access(31'd8192);
      send_access(31'd12288);
      send_access(31'd4100);
      drain();
      write_reg(CSR_POLICY, CSR_DATA_W'(POLICY_LRU));
      send_access(31'd4096);
      send_access(31'd20480);
      drain();
      write_reg(CSR_PAGE_SIZE, '0);          // zero page size acts as 1
      send_access(31'd7);
      send_access(ADDR_MAX);
      drain();
      write_reg(CSR_CAPACITY, '0);           // zero capacity acts as 1
      send_access(31'd9);
      send_access(31'd9);
      send_access(31'd10);
      drain();
      write_reg(CSR_PAGE_SIZE, 16'hFFFF);
      write_reg(CSR_CAPACITY, 16'h001F);     // saturates at ENTRIES
      send_access(ADDR_MAX);
      send_access(31'd65534);
      send_access(31'd65535);
      drain();
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_access('0);
      send_access(ADDR_MAX);
      drain();
   endtask

   task automatic random_phase(input int phase);
      logic [PSIZE_W-1:0] ps;
      logic [CAP_W-1:0]   cap;
      logic               pol;
      longint unsigned    divisor;
      longint unsigned    max_page;
      longint unsigned    pool[$];
      int                 pool_size;
      logic [ADDR_W-1:0]  addr;
      case (phase)
         0: begin ps = 16'd1;    cap = 5'd0;  pol = POLICY_LRU;  end
         1: begin ps = 16'hFFFF; cap = 5'd31; pol = POLICY_FIFO; end
         2: begin ps = 16'd0;    cap = 5'd16; pol = POLICY_LRU;  end
         3: begin ps = 16'd4096; cap = 5'd1;  pol = POLICY_FIFO; end
         default: begin
            case ($urandom_range(0, 4))
               0: ps = PSIZE_W'($urandom_range(1, 16));
               1: ps = PSIZE_W'(32'hFFFF - $urandom_range(0, 15));
               2: ps = 16'd4096;
               default: ps = PSIZE_W'($urandom_range(1, 65535));
            endcase
            cap = CAP_W'($urandom_range(0, 31));
            pol = 1'($urandom_range(0, 1));
         end
      endcase
      write_reg(CSR_PAGE_SIZE, ps);
      write_reg(CSR_CAPACITY, {11'($urandom), cap});
      write_reg(CSR_POLICY, {15'($urandom), pol});
      if ($urandom_range(0, 4) == 0)
         write_reg(CSR_UNUSED, 16'($urandom));
      quiet = (phase == 1) || ($urandom_range(0, 3) == 0);

      divisor   = (ps == 0) ? 1 : ps;
      max_page  = ADDR_MAX / divisor;
      pool_size = ((cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap) + $urandom_range(0, 6);
      pool = {pool, 64'd0};
      pool = {pool, max_page};
      while (pool.size() < pool_size)
         pool = {pool, {$urandom, $urandom} % (max_page + 1)};

      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(0, 9) == 0)
            addr = ADDR_W'($urandom);
         else
            addr = addr_in_page(pool[$urandom_range(0, pool.size() - 1)], divisor);
         send_access(addr);
      end
      drain();
   endtask

   initial begin
      shadow          = new();
      quiet           = 1'b0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.address = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_checks();
      for (int p = 0; p < NUM_PHASES; p++)
         random_phase(p);
      drain();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (shadow.errors == 0 && shadow.outstanding() == 0)
         $display("tb_tlb_fifo_lru_lookup_unit: done, clean");
      else
         $display("tb_tlb_fifo_lru_lookup_unit: done, errors");
      $finish;
   end

   initial begin : response_sink
      int                stall;
      lookup_result_type got;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.page_number  = rsp_bus.page_number;
         got.hit          = rsp_bus.hit;
         got.victim_valid = rsp_bus.victim_valid;
         got.victim_page  = rsp_bus.victim_page;
         got.hit_count    = rsp_bus.hit_count;
         got.miss_count   = rsp_bus.miss_count;
         shadow.check_result(got);
         @(negedge clock);
      end
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/tlbfl_pkg.sv
rtl/core/tlbfl_req_if.sv
rtl/core/tlbfl_rsp_if.sv
rtl/core/tlbfl_div.sv
rtl/core/tlbfl_cell.sv
rtl/core/tlb_fifo_lru_lookup_unit.sv
tb/tb_tlb_fifo_lru_lookup_unit.sv
